>>> sv/tsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and the arctangent table of the solid angle block.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int unsigned CordicSteps = 32;
  localparam int unsigned OutW = 31;
  localparam logic [63:0] PiUnits = 64'd13493037705;
  localparam logic [63:0] OutMax = 64'd1686629713;

  typedef struct packed {
    logic               vld;
    logic               xneg;
    logic               zero;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cordic_t;

  function automatic logic signed [63:0] atan_units(input logic [4:0] idx);
    logic signed [63:0] r;
    case (idx)
      5'd0: r = 64'sd3373259426;
      5'd1: r = 64'sd1991351318;
      5'd2: r = 64'sd1052175346;
      5'd3: r = 64'sd534100635;
      5'd4: r = 64'sd268086748;
      5'd5: r = 64'sd134174063;
      5'd6: r = 64'sd67103403;
      5'd7: r = 64'sd33553749;
      5'd8: r = 64'sd16777131;
      5'd9: r = 64'sd8388597;
      5'd10: r = 64'sd4194303;
      default: r = 64'sd1 <<< (6'd32 - {1'b0, idx});
    endcase
    return r;
  endfunction

endpackage

>>> sv/tsa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_cell
// One vectoring rotation of the arctangent chain, registered.
// ----------------------------------------------------------------------------
module tsa_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [4:0]       idx_i,
  input  tsa_pkg::cordic_t cell_i,
  output tsa_pkg::cordic_t cell_o
);

  tsa_pkg::cordic_t cell_d, cell_q;
  logic vld_q;
  logic signed [63:0] xs, ys, ang;

  always_comb begin
    xs = cell_i.x >>> idx_i;
    ys = cell_i.y >>> idx_i;
    ang = tsa_pkg::atan_units(idx_i);
    cell_d = cell_i;
    if (!cell_i.y[63]) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ang;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  always_comb begin
    cell_o = cell_q;
    cell_o.vld = vld_q;
  end

endmodule

>>> sv/tsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_front
// Pipelined geometry: edges, scaling, triple product, lengths, denominator
// and normalization to the arctangent input.
// ----------------------------------------------------------------------------
module tsa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] pt_i [12],
  output tsa_pkg::cordic_t   cell_o
);

  localparam int unsigned SqrtSteps = 34;

  // Stage 1: edge vectors.
  logic               v1_q;
  logic signed [32:0] e1_q [9];
  // Stage 2: common scale.
  logic               v2_q;
  logic signed [32:0] s2_q [9];
  // Stage 3: products of pairs.
  logic               v3_q;
  logic signed [65:0] p3_q [3];
  logic [65:0]        sq3_q [3];
  logic signed [66:0] dot3_q [3];
  logic signed [32:0] a3_q [3];
  // Square root chain, two radicand bits per stage.
  logic               vs_q [SqrtSteps+1];
  logic [67:0]        rad_q [SqrtSteps][3];
  logic [33:0]        rem_q [SqrtSteps][3];
  logic [33:0]        rt_q [SqrtSteps+1][3];
  logic signed [66:0] dotc_q [SqrtSteps+1][3];
  logic signed [32:0] ac_q [SqrtSteps+1][3];
  logic signed [65:0] cr_q [SqrtSteps+1][3];
  logic [33:0]        rem_n [SqrtSteps][3];
  logic [33:0]        rt_n [SqrtSteps][3];
  logic [35:0]        sq_cur, sq_trial;
  // Split wide products.
  logic               vm1_q, vm2_q;
  logic signed [67:0] phm_q [3];
  logic signed [67:0] plm_q [3];
  logic signed [67:0] dhm_q [3];
  logic signed [67:0] dlm_q [3];
  logic [65:0]        nab_q;
  logic [33:0]        nc_q;
  logic signed [127:0] det2_q, dsum_q;
  logic [65:0]        nbh_q, nbl_q;
  // Final stages.
  logic                vf_q;
  logic signed [127:0] det_q, den_q;
  logic [127:0]        ym_q, xm_q;
  logic                xn_q, v5_q;

  logic [5:0] bl;
  logic [32:0] maxabs, mag;

  always_comb begin
    maxabs = '0;
    for (int i = 0; i < 9; i++) begin
      mag = e1_q[i][32] ? 33'(-e1_q[i]) : e1_q[i];
      maxabs = maxabs | mag;
    end
    bl = '0;
    for (int i = 0; i < 33; i++) begin
      if (maxabs[i]) bl = 6'(i + 1);
    end
  end

  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      for (int j = 0; j < 3; j++) begin
        sq_cur = {rem_q[k][j], rad_q[k][j][67 - 2*k -: 2]};
        sq_trial = {rt_q[k][j], 2'b01};
        if (sq_cur >= sq_trial) begin
          rem_n[k][j] = 34'(sq_cur - sq_trial);
          rt_n[k][j] = {rt_q[k][j][32:0], 1'b1};
        end else begin
          rem_n[k][j] = sq_cur[33:0];
          rt_n[k][j] = {rt_q[k][j][32:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vf_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) vs_q[k] <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vs_q[0] <= v3_q;
      for (int k = 1; k <= SqrtSteps; k++) vs_q[k] <= vs_q[k-1];
      vm1_q <= vs_q[SqrtSteps];
      vm2_q <= vm1_q;
      vf_q <= vm2_q;
      v5_q <= vf_q;
    end
  end

  logic [127:0] lenv;
  int ly;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        e1_q[i] <= 33'(pt_i[3 + i]) - 33'(pt_i[i % 3]);
      end
      for (int i = 0; i < 9; i++) begin
        s2_q[i] <= (bl != 0 && bl < 32) ? (e1_q[i] <<< (6'd32 - bl)) : e1_q[i];
      end
      p3_q[0] <= 66'(s2_q[4]) * 66'(s2_q[8]) - 66'(s2_q[5]) * 66'(s2_q[7]);
      p3_q[1] <= 66'(s2_q[5]) * 66'(s2_q[6]) - 66'(s2_q[3]) * 66'(s2_q[8]);
      p3_q[2] <= 66'(s2_q[3]) * 66'(s2_q[7]) - 66'(s2_q[4]) * 66'(s2_q[6]);
      for (int j = 0; j < 3; j++) begin
        sq3_q[j] <= 66'(s2_q[3*j]) * 66'(s2_q[3*j]) + 66'(s2_q[3*j+1]) * 66'(s2_q[3*j+1])
                  + 66'(s2_q[3*j+2]) * 66'(s2_q[3*j+2]);
        a3_q[j] <= s2_q[j];
      end
      dot3_q[0] <= 67'(s2_q[0]) * 67'(s2_q[3]) + 67'(s2_q[1]) * 67'(s2_q[4])
                 + 67'(s2_q[2]) * 67'(s2_q[5]);
      dot3_q[1] <= 67'(s2_q[0]) * 67'(s2_q[6]) + 67'(s2_q[1]) * 67'(s2_q[7])
                 + 67'(s2_q[2]) * 67'(s2_q[8]);
      dot3_q[2] <= 67'(s2_q[3]) * 67'(s2_q[6]) + 67'(s2_q[4]) * 67'(s2_q[7])
                 + 67'(s2_q[5]) * 67'(s2_q[8]);
      for (int j = 0; j < 3; j++) begin
        rad_q[0][j] <= {2'b00, sq3_q[j]};
        rem_q[0][j] <= '0;
        rt_q[0][j] <= '0;
        dotc_q[0][j] <= dot3_q[j];
        ac_q[0][j] <= a3_q[j];
        cr_q[0][j] <= p3_q[j];
      end
      for (int k = 1; k <= SqrtSteps; k++) begin
        for (int j = 0; j < 3; j++) begin
          rt_q[k][j] <= rt_n[k-1][j];
          dotc_q[k][j] <= dotc_q[k-1][j];
          ac_q[k][j] <= ac_q[k-1][j];
          cr_q[k][j] <= cr_q[k-1][j];
        end
      end
      for (int k = 1; k < SqrtSteps; k++) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= rem_n[k-1][j];
          rad_q[k][j] <= rad_q[k-1][j];
        end
      end
      for (int j = 0; j < 3; j++) begin
        phm_q[j] <= 68'(ac_q[SqrtSteps][j]) * 68'($signed(cr_q[SqrtSteps][j][65:33]));
        plm_q[j] <= 68'(ac_q[SqrtSteps][j])
                  * 68'($signed({1'b0, cr_q[SqrtSteps][j][32:0]}));
        dhm_q[j] <= 68'($signed(dotc_q[SqrtSteps][j][66:33]))
                  * 68'($signed({1'b0, rt_q[SqrtSteps][2-j]}));
        dlm_q[j] <= 68'($signed({1'b0, dotc_q[SqrtSteps][j][32:0]}))
                  * 68'($signed({1'b0, rt_q[SqrtSteps][2-j]}));
      end
      nab_q <= 66'(rt_q[SqrtSteps][0]) * 66'(rt_q[SqrtSteps][1]);
      nc_q <= rt_q[SqrtSteps][2];
      det2_q <= (128'(phm_q[0]) <<< 33) + 128'(plm_q[0])
              + (128'(phm_q[1]) <<< 33) + 128'(plm_q[1])
              + (128'(phm_q[2]) <<< 33) + 128'(plm_q[2]);
      dsum_q <= (128'(dhm_q[0]) <<< 33) + 128'(dlm_q[0])
              + (128'(dhm_q[1]) <<< 33) + 128'(dlm_q[1])
              + (128'(dhm_q[2]) <<< 33) + 128'(dlm_q[2]);
      nbh_q <= 66'(nab_q[65:33]) * 66'(nc_q);
      nbl_q <= 66'(nab_q[32:0]) * 66'(nc_q);
      det_q <= det2_q;
      den_q <= $signed({29'd0, nbh_q, 33'd0}) + $signed({62'd0, nbl_q}) + dsum_q;
      ym_q <= det_q[127] ? 128'(-det_q) : 128'(det_q);
      xm_q <= den_q[127] ? 128'(-den_q) : 128'(den_q);
      xn_q <= den_q[127];
    end
  end

  always_comb begin
    lenv = ym_q | xm_q;
    ly = 0;
    for (int i = 0; i < 128; i++) begin
      if (lenv[i]) ly = i + 1;
    end
    cell_o.vld = v5_q;
    cell_o.xneg = xn_q;
    cell_o.zero = (ly == 0);
    cell_o.z = '0;
    if (ly > 61) begin
      cell_o.x = 64'(xm_q >> (ly - 61));
      cell_o.y = 64'(ym_q >> (ly - 61));
    end else begin
      cell_o.x = 64'(xm_q << (61 - ly));
      cell_o.y = 64'(ym_q << (61 - ly));
    end
  end

endmodule

>>> sv/triangle_solid_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_solid_angle_top
// Solid angle of a triangle seen from an apex, by the triple product and
// a chain of arctangent rotation cells.
// ----------------------------------------------------------------------------
// channel  signals                          direction
// in       in_valid_i/in_ready_o, 12 coords  input
// out      out_valid_o/out_ready_i, omega    output
// One triangle per cycle is taken while the output is not stalled; each
// triangle passes through the edge, scale and product stages, the square root stages,
// 4 product and normalization stages, the 32 rotation cells and the output
// register. A stalled output freezes the whole pipeline in place.
// Reset clears all valid bits.
// ----------------------------------------------------------------------------
module triangle_solid_angle_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] apex_x_i,
  input  logic signed [31:0] apex_y_i,
  input  logic signed [31:0] apex_z_i,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] first_z_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic signed [31:0] second_z_i,
  input  logic signed [31:0] third_x_i,
  input  logic signed [31:0] third_y_i,
  input  logic signed [31:0] third_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        omega_o
);

  logic en;
  logic signed [31:0] pts [12];
  tsa_pkg::cordic_t chain [tsa_pkg::CordicSteps+1];
  logic out_vld_q;
  logic [30:0] out_q;
  logic signed [63:0] zc;
  logic [63:0] r;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign pts = '{apex_x_i, apex_y_i, apex_z_i, first_x_i, first_y_i, first_z_i,
                 second_x_i, second_y_i, second_z_i, third_x_i, third_y_i, third_z_i};

  tsa_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(in_valid_i),
    .pt_i(pts), .cell_o(chain[0])
  );

  for (genvar g = 0; g < tsa_pkg::CordicSteps; g++) begin : g_cell
    tsa_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .idx_i(5'(g)),
      .cell_i(chain[g]), .cell_o(chain[g+1])
    );
  end

  always_comb begin
    zc = chain[tsa_pkg::CordicSteps].z;
    if (zc < 0) zc = '0;
    if (zc > $signed(tsa_pkg::PiUnits)) zc = $signed(tsa_pkg::PiUnits);
    if (chain[tsa_pkg::CordicSteps].xneg) zc = $signed(tsa_pkg::PiUnits) - zc;
    r = (64'(zc) + 64'd4) >> 3;
    if (r > tsa_pkg::OutMax) r = tsa_pkg::OutMax;
    if (chain[tsa_pkg::CordicSteps].zero) r = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[tsa_pkg::CordicSteps].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= r[30:0];
  end

  assign out_valid_o = out_vld_q;
  assign omega_o = out_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(omega_o))
    else $error("output changed while stalled");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> omega_o <= 31'(tsa_pkg::OutMax))
    else $error("angle out of range");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");
`endif

endmodule
